FILE: rtl/core/local_peak_window_finder_macros.svh
// assertion macros for the local peak window finder
// used by the modules under rtl/core
`ifndef LOCAL_PEAK_WINDOW_FINDER_MACROS_SVH
`define LOCAL_PEAK_WINDOW_FINDER_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define LPW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define LPW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/core/lpw_pkg.sv
// package for the local peak window finder: item types, trend codes, stack command and series limit
// no dependencies
`default_nettype none
package lpw_pkg;
  // a series is cut off at this many samples
  localparam int MAX_SERIES_LENGTH = 65536;
  typedef struct packed {
    logic signed [31:0] sample;
    logic               last_sample;
  } lpw_in_t;
  typedef struct packed {
    logic        peak_valid;
    logic [15:0] peak_index;
    logic [16:0] window_size;
    logic        end_of_series;
    logic        overflow;
  } lpw_out_t;
  localparam logic [1:0] TREND_START = 2'd0;
  localparam logic [1:0] TREND_FALL  = 2'd1;
  localparam logic [1:0] TREND_FLAT  = 2'd2;
  localparam logic [1:0] TREND_RISE  = 2'd3;
  // command from the sequencer to the stack cell rows
  typedef struct packed {
    logic push;    // push head entry, shifting others down
    logic pop;     // pop head entry
  } lpw_stk_cmd_t;
endpackage
`default_nettype wire

FILE: rtl/core/lpw_cell.sv
// one cell of a shift stack: holds a value, an index and a left bound
// depends on lpw_pkg
`default_nettype none
module lpw_cell import lpw_pkg::*; (
  input  wire logic               clk_i,
  input  wire lpw_stk_cmd_t       cmd_i,
  input  wire logic signed [31:0] up_val_i,
  input  wire logic [15:0]        up_idx_i,
  input  wire logic [17:0]        up_left_i,
  input  wire logic signed [31:0] dn_val_i,
  input  wire logic [15:0]        dn_idx_i,
  input  wire logic [17:0]        dn_left_i,
  output logic signed [31:0]      val_o,
  output logic [15:0]             idx_o,
  output logic [17:0]             left_o
);
  logic signed [31:0] val_q;
  logic [15:0]        idx_q;
  logic [17:0]        left_q;
  // push takes from the neighbor above, pop from the one below
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      val_q <= up_val_i; idx_q <= up_idx_i; left_q <= up_left_i;
    end else if (cmd_i.pop) begin
      val_q <= dn_val_i; idx_q <= dn_idx_i; left_q <= dn_left_i;
    end
  end
  assign val_o  = val_q;
  assign idx_o  = idx_q;
  assign left_o = left_q;
endmodule
`default_nettype wire

FILE: rtl/core/lpw_stack.sv
// stack built from a row of lpw_cell, top of stack in cell 0
// depends on lpw_pkg and lpw_cell
`default_nettype none
module lpw_stack import lpw_pkg::*; #(
  parameter int Depth = 64
) (
  input  wire logic               clk_i,
  input  wire lpw_stk_cmd_t       cmd_i,
  input  wire logic signed [31:0] val_i,
  input  wire logic [15:0]        idx_i,
  input  wire logic [17:0]        left_i,
  output logic signed [31:0]      top_val_o,
  output logic [15:0]             top_idx_o,
  output logic [17:0]             top_left_o,
  output logic [15:0]             second_idx_o
);
  logic signed [31:0] val_w  [Depth+1];
  logic [15:0]        idx_w  [Depth+1];
  logic [17:0]        left_w [Depth+1];
  lpw_stk_cmd_t       ccmd;
  // a push on a full stack shifts the bottom entry out of the last cell
  assign ccmd = '{push: cmd_i.push, pop: cmd_i.pop};
  assign val_w[Depth]  = '0;
  assign idx_w[Depth]  = '0;
  assign left_w[Depth] = '0;
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic signed [31:0] uv;
    logic [15:0]        ui;
    logic [17:0]        ul;
    if (g == 0) begin : g_head
      assign uv = val_i; assign ui = idx_i; assign ul = left_i;
    end else begin : g_body
      assign uv = val_w[g-1]; assign ui = idx_w[g-1]; assign ul = left_w[g-1];
    end
    lpw_cell u_cell (
      .clk_i, .cmd_i(ccmd),
      .up_val_i(uv), .up_idx_i(ui), .up_left_i(ul),
      .dn_val_i(val_w[g+1]), .dn_idx_i(idx_w[g+1]), .dn_left_i(left_w[g+1]),
      .val_o(val_w[g]), .idx_o(idx_w[g]), .left_o(left_w[g])
    );
  end
  assign top_val_o    = val_w[0];
  assign top_idx_o    = idx_w[0];
  assign top_left_o   = left_w[0];
  assign second_idx_o = idx_w[1];
endmodule
`default_nettype wire

FILE: rtl/core/local_peak_window_finder.sv
// top level of the local peak window finder: sequencer and two cell stacks
// depends on lpw_pkg, lpw_stack and the macros header
//
// channel  dir  handshake                  payload
// in       in   in_valid_i / in_ready_o    lpw_in_t
// out      out  out_valid_o / out_ready_i  lpw_out_t
//
// an item steps through idle, one greater-stack pop per step then the push, one resolved peak per step, and new peak;
// the final item of a series then drains one peak per step and ends in the empty state
// the pops and resolves walk the cell stacks one entry per cycle, the resolves only while no result is stalled
// reset clears the control state; stack cells need no reset
// a stalled result holds the sequencer in the states that emit results, input waits until the item is done
`default_nettype none
`include "local_peak_window_finder_macros.svh"
module local_peak_window_finder import lpw_pkg::*; #(
  parameter int GREATER_STACK_DEPTH = 64,
  parameter int PENDING_PEAK_DEPTH  = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire lpw_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output lpw_out_t      out_data_o
);
  localparam int GW = $clog2(GREATER_STACK_DEPTH + 1);
  localparam int PW = $clog2(PENDING_PEAK_DEPTH + 1);
  localparam int CW = $clog2(MAX_SERIES_LENGTH);
  localparam logic [2:0] S_IDLE = 3'd0, S_GPOP = 3'd1, S_PRES = 3'd2,
                         S_NEWP = 3'd3, S_DRAIN = 3'd4, S_EMPTY = 3'd5;

  logic [2:0]  st_q, st_d;
  logic [1:0]  trend_q, trend_d;
  logic        plat_q, plat_d;
  logic [15:0] pbeg_q, pbeg_d;
  logic [17:0] pleft_q, pleft_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic signed [31:0] prev_q, prev_d;
  logic [GW-1:0] gfill_q, gfill_d;
  logic [PW-1:0] pfill_q, pfill_d;
  logic        ovf_q, ovf_d;
  logic signed [31:0] s_q, s_d;
  logic [CW-1:0] idx_q, idx_d;
  logic        last_q, last_d;
  logic        np_q, np_d;
  logic [15:0] pc_q, pc_d;
  logic [17:0] pl_q, pl_d;
  logic        emitted_q, emitted_d;
  logic        ov_q, ov_d;
  lpw_out_t    od_q, od_d;
  lpw_stk_cmd_t gcmd, pcmd;
  logic signed [31:0] gtop_val, ptop_val;
  logic [15:0] gtop_idx, gsec_idx, ptop_idx, psec_unused;
  logic [17:0] gtop_left, ptop_left;
  logic [17:0] left_now;
  logic [1:0]  curr;
  logic        last_in;
  logic [16:0] sum;
  logic [17:0] right;
  logic        fin_pres, fin_newp, fin_drain;

  assign in_ready_o  = (st_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign last_in = in_data_i.last_sample || (cnt_q == CW'(MAX_SERIES_LENGTH - 1));
  assign curr = (in_data_i.sample > prev_q) ? TREND_RISE :
                (in_data_i.sample < prev_q) ? TREND_FALL : TREND_FLAT;
  assign left_now = (gfill_q >= GW'(2)) ? {2'b00, gsec_idx} : 18'h3FFFF;
  assign sum = 17'(pbeg_q) + 17'(cnt_q - CW'(1));

  // which result is the last one of a series end
  assign fin_pres  = last_q && (pfill_q == PW'(1)) && !np_q;
  assign fin_newp  = (pfill_q == '0);
  assign fin_drain = (pfill_q == PW'(1));

  lpw_stack #(.Depth(GREATER_STACK_DEPTH)) u_gstk (
    .clk_i, .cmd_i(gcmd), .val_i(s_q), .idx_i(16'(idx_q)), .left_i('0),
    .top_val_o(gtop_val), .top_idx_o(gtop_idx), .top_left_o(gtop_left),
    .second_idx_o(gsec_idx));
  lpw_stack #(.Depth(PENDING_PEAK_DEPTH)) u_pstk (
    .clk_i, .cmd_i(pcmd), .val_i(prev_q), .idx_i(pc_q), .left_i(pl_q),
    .top_val_o(ptop_val), .top_idx_o(ptop_idx), .top_left_o(ptop_left),
    .second_idx_o(psec_unused));

  // sequencer
  always_comb begin
    st_d = st_q; trend_d = trend_q; plat_d = plat_q; pbeg_d = pbeg_q;
    pleft_d = pleft_q; cnt_d = cnt_q; prev_d = prev_q; gfill_d = gfill_q;
    pfill_d = pfill_q; ovf_d = ovf_q; s_d = s_q; idx_d = idx_q;
    last_d = last_q; np_d = np_q; pc_d = pc_q; pl_d = pl_q;
    emitted_d = emitted_q; ov_d = ov_q; od_d = od_q;
    gcmd = '0; pcmd = '0;
    right = last_q ? 18'(idx_q) + 18'd1 : 18'(idx_q);
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          s_d = in_data_i.sample; idx_d = cnt_q; last_d = last_in;
          np_d = 1'b0; pc_d = '0; pl_d = 18'h3FFFF; emitted_d = 1'b0;
          if (cnt_q != '0) begin
            case (trend_q)
              TREND_RISE: begin
                if (curr == TREND_FALL) begin
                  np_d = 1'b1; pc_d = 16'(cnt_q - CW'(1)); pl_d = left_now;
                  plat_d = 1'b0;
                end else if (curr == TREND_FLAT) begin
                  plat_d = 1'b1; pbeg_d = 16'(cnt_q - CW'(1)); pleft_d = left_now;
                end else plat_d = 1'b0;
              end
              TREND_FLAT: begin
                if (curr == TREND_FALL && plat_q) begin
                  np_d = 1'b1; pc_d = sum[16:1]; pl_d = pleft_q; plat_d = 1'b0;
                end else if (curr == TREND_RISE) plat_d = 1'b0;
              end
              default: plat_d = 1'b0;
            endcase
            trend_d = curr;
          end
          st_d = S_GPOP;
        end
      end
      // pop greater stack entries not above the sample, then push it
      S_GPOP: begin
        if (gfill_q != '0 && gtop_val <= s_q) begin
          gcmd.pop = 1'b1; gfill_d = gfill_q - GW'(1);
        end else begin
          gcmd.push = 1'b1;
          if (gfill_q >= GW'(GREATER_STACK_DEPTH)) ovf_d = 1'b1;
          else gfill_d = gfill_q + GW'(1);
          st_d = S_PRES;
        end
      end
      // resolve pending peaks lower than the sample
      S_PRES: begin
        if (!ov_q || out_ready_i) begin
          if (pfill_q != '0 && ptop_val < s_q) begin
            pcmd.pop = 1'b1; pfill_d = pfill_q - PW'(1);
            od_d = '{1'b1, ptop_idx, 17'(18'(idx_q) - ptop_left - 18'd1), fin_pres, ovf_q};
            ov_d = 1'b1; emitted_d = 1'b1;
          end else st_d = S_NEWP;
        end
      end
      S_NEWP: begin
        if (!ov_q || out_ready_i) begin
          st_d = last_q ? S_DRAIN : S_IDLE;
          if (np_q) begin
            if (last_q) begin
              od_d = '{1'b1, pc_q, 17'(right - pl_q - 18'd1), fin_newp, ovf_q};
              ov_d = 1'b1; emitted_d = 1'b1;
            end else if (pfill_q >= PW'(PENDING_PEAK_DEPTH)) ovf_d = 1'b1;
            else begin
              pcmd.push = 1'b1; pfill_d = pfill_q + PW'(1);
            end
          end
          if (!last_q) begin
            prev_d = s_q; cnt_d = idx_q + CW'(1);
          end
        end
      end
      // flush remaining peaks at series end; last result marks the end
      S_DRAIN: begin
        if (!ov_q || out_ready_i) begin
          if (pfill_q != '0) begin
            pcmd.pop = 1'b1; pfill_d = pfill_q - PW'(1);
            od_d = '{1'b1, ptop_idx, 17'(right - ptop_left - 18'd1), fin_drain, ovf_q};
            ov_d = 1'b1; emitted_d = 1'b1;
          end else st_d = S_EMPTY;
        end
      end
      // end marker when no peak was reported, then clear the series
      S_EMPTY: begin
        if (!ov_q || out_ready_i) begin
          if (!emitted_q) begin
            od_d = '{1'b0, 16'd0, 17'd0, 1'b1, ovf_q};
            ov_d = 1'b1;
          end
          trend_d = TREND_START; plat_d = 1'b0; pbeg_d = '0; pleft_d = '0;
          cnt_d = '0; prev_d = '0; gfill_d = '0; pfill_d = '0; ovf_d = 1'b0;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // control registers with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; trend_q <= TREND_START; plat_q <= 1'b0; pbeg_q <= '0;
      pleft_q <= '0; cnt_q <= '0; prev_q <= '0; gfill_q <= '0; pfill_q <= '0;
      ovf_q <= 1'b0; ov_q <= 1'b0; emitted_q <= 1'b0;
    end else begin
      st_q <= st_d; trend_q <= trend_d; plat_q <= plat_d; pbeg_q <= pbeg_d;
      pleft_q <= pleft_d; cnt_q <= cnt_d; prev_q <= prev_d; gfill_q <= gfill_d;
      pfill_q <= pfill_d; ovf_q <= ovf_d; ov_q <= ov_d; emitted_q <= emitted_d;
    end
  end
  // item and result data registers
  always_ff @(posedge clk_i) begin
    s_q <= s_d; idx_q <= idx_d; last_q <= last_d; np_q <= np_d;
    pc_q <= pc_d; pl_q <= pl_d; od_q <= od_d;
  end

  `LPW_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, pfill_q <= PW'(PENDING_PEAK_DEPTH), "pfill")
  `LPW_ASSERT_IMP(a_gfill_bound, clk_i, rst_ni, 1'b1, gfill_q <= GW'(GREATER_STACK_DEPTH), "gfill")
  `LPW_ASSERT_NXT(a_hold, clk_i, rst_ni, ov_q && !out_ready_i, ov_q && $stable(od_q), "held")
endmodule
`default_nettype wire
